FILE: hdl/dfr_pkg.sv
// ----------------------------------------------------------------------------
// dfr_pkg
// shared types and constants for the double remainder block
// ----------------------------------------------------------------------------
package dfr_pkg;

   localparam int unsigned FRAC_BITS = 52;
   localparam int unsigned EXP_BITS = 11;
   localparam logic [63:0] QNAN_BITS = 64'h7FF8000000000000;

   // signed exponent wide enough for subnormal adjustment
   typedef logic signed [12:0] exp_type;

   typedef struct packed {
      logic load;
      logic norm_x;
      logic norm_y;
      logic step;
      logic last_sub;
      logic norm_r;
   } cmd_type;

   typedef struct packed {
      logic special;
      logic x_norm_done;
      logic y_norm_done;
      logic step_done;
      logic zero_hit;
      logic r_norm_done;
   } sts_type;

endpackage

FILE: hdl/dfr_datapath.sv
// ----------------------------------------------------------------------------
// dfr_datapath
// unpack, shift-subtract, normalize and repack registers
// ----------------------------------------------------------------------------
module dfr_datapath
   import dfr_pkg::*;
(
   input  logic        clock,
   input  logic [63:0] x_bits,
   input  logic [63:0] y_bits,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic [63:0] result
);

   logic [63:0] lx_ff, lx_in, ly_ff, ly_in;
   exp_type     ex_ff, ex_in, ey_ff, ey_in;
   logic        sign_ff, sign_in;
   logic [63:0] res_ff, res_in;
   logic        spec_ff, spec_in;

   logic [63:0] xm, ym, d;
   logic [10:0] ex_raw, ey_raw;
   logic        y_nan;
   logic [5:0]  sh;
   logic signed [13:0] shw;

   assign xm     = {x_bits[62:0], 1'b0};
   assign ym     = {y_bits[62:0], 1'b0};
   assign ex_raw = x_bits[62:52];
   assign ey_raw = y_bits[62:52];
   assign y_nan  = ym > 64'hFFE0000000000000;
   assign d      = lx_ff - ly_ff;
   assign shw    = 14'sd1 - 14'(ex_ff);
   assign sh     = shw[5:0];

   always_comb begin
      lx_in = lx_ff; ly_in = ly_ff; ex_in = ex_ff; ey_in = ey_ff;
      sign_in = sign_ff; res_in = res_ff; spec_in = spec_ff;
      if (cmd.load) begin
         sign_in = x_bits[63];
         spec_in = 1'b1;
         if (ym == 64'd0 || y_nan || ex_raw == 11'h7FF) begin
            res_in = QNAN_BITS;
         end else if (xm == ym) begin
            res_in = {x_bits[63], 63'd0};
         end else if (xm < ym) begin
            res_in = x_bits;
         end else begin
            spec_in = 1'b0;
         end
         // subnormals start at exponent 1 with raw fraction; normalized below
         lx_in = (ex_raw == 11'd0) ? {12'd0, x_bits[51:0]} : {11'd0, 1'b1, x_bits[51:0]};
         ly_in = (ey_raw == 11'd0) ? {12'd0, y_bits[51:0]} : {11'd0, 1'b1, y_bits[51:0]};
         ex_in = (ex_raw == 11'd0) ? 13'sd1 : exp_type'({2'b0, ex_raw});
         ey_in = (ey_raw == 11'd0) ? 13'sd1 : exp_type'({2'b0, ey_raw});
      end
      if (cmd.norm_x && !lx_ff[52]) begin
         lx_in = {lx_ff[62:0], 1'b0};
         ex_in = ex_ff - 13'sd1;
      end
      if (cmd.norm_y && !ly_ff[52]) begin
         ly_in = {ly_ff[62:0], 1'b0};
         ey_in = ey_ff - 13'sd1;
      end
      if (cmd.step || cmd.last_sub) begin
         if (!d[63] && d == 64'd0) begin
            res_in = {sign_ff, 63'd0};
         end else begin
            lx_in = d[63] ? lx_ff : d;
            if (cmd.step) begin
               lx_in = {lx_in[62:0], 1'b0};
               ex_in = ex_ff - 13'sd1;
            end
         end
      end
      if (cmd.norm_r) begin
         if (!lx_ff[52]) begin
            lx_in = {lx_ff[62:0], 1'b0};
            ex_in = ex_ff - 13'sd1;
         end else if (ex_ff > 13'sd0) begin
            res_in = {sign_ff, ex_ff[10:0], lx_ff[51:0]};
         end else begin
            // remainder is exact, shift stays below 64
            res_in = {sign_ff, 63'd0} | (lx_ff >> sh);
         end
      end
   end

   always_ff @(posedge clock) begin
      lx_ff <= lx_in; ly_ff <= ly_in; ex_ff <= ex_in; ey_ff <= ey_in;
      sign_ff <= sign_in; res_ff <= res_in; spec_ff <= spec_in;
   end

   assign sts.special     = spec_ff;
   assign sts.x_norm_done = lx_ff[52];
   assign sts.y_norm_done = ly_ff[52];
   assign sts.step_done   = !(ex_ff > ey_ff);
   assign sts.zero_hit    = !d[63] && d == 64'd0;
   assign sts.r_norm_done = lx_ff[52];
   assign result          = res_ff;

endmodule

FILE: hdl/dfr_control.sv
// ----------------------------------------------------------------------------
// dfr_control
// sequencer for the remainder datapath and handshake
// ----------------------------------------------------------------------------
module dfr_control
   import dfr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_CHECK = 7'b0000010,
      S_NORMX = 7'b0000100,
      S_NORMY = 7'b0001000,
      S_STEP  = 7'b0010000,
      S_NORMR = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic accept;

   assign req_stall = state_ff != S_IDLE;
   assign accept    = req_valid && state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_OUT;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.load = accept;
            if (accept) state_in = S_CHECK;
         end
         S_CHECK: state_in = sts.special ? S_OUT : S_NORMX;
         S_NORMX: begin
            cmd.norm_x = 1'b1;
            if (sts.x_norm_done) state_in = S_NORMY;
         end
         S_NORMY: begin
            cmd.norm_y = 1'b1;
            if (sts.y_norm_done) state_in = S_STEP;
         end
         S_STEP: begin
            // one shift-subtract per unit of exponent difference, then a final conditional subtract
            cmd.step     = !sts.step_done;
            cmd.last_sub = sts.step_done;
            if (sts.zero_hit) state_in = S_OUT;
            else if (sts.step_done) state_in = S_NORMR;
         end
         S_NORMR: begin
            cmd.norm_r = 1'b1;
            if (sts.r_norm_done) state_in = S_OUT;
         end
         S_OUT: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped under stall");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall) else $error("request taken while busy");
   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.norm_x, cmd.norm_y, cmd.step || cmd.last_sub, cmd.norm_r}))
      else $error("overlapping datapath commands");

endmodule

FILE: hdl/double_float_remainder.sv
// ----------------------------------------------------------------------------
// double_float_remainder
// binary64 truncated remainder, sign of dividend, restoring shift-subtract
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  req_      in         dividend_bits, divisor_bits
//  rsp_      out        remainder_bits
//
//  special cases go straight to the output; otherwise x and y are normalized,
//  the single shared subtractor steps once per exponent unit (ending early on
//  a zero remainder), and the remainder is normalized and repacked
//  one request at a time; req_stall is high from accept until rsp is taken
//  reset is synchronous and returns the sequencer to idle
module double_float_remainder
   import dfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_dividend_bits,
   input  logic [63:0] req_divisor_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_remainder_bits
);

   cmd_type cmd;
   sts_type sts;

   dfr_control u_ctl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .sts, .cmd
   );

   dfr_datapath u_dp (
      .clock, .x_bits(req_dividend_bits), .y_bits(req_divisor_bits),
      .cmd, .sts, .result(rsp_remainder_bits)
   );

endmodule
